[src/rwp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE PCM parser package
// Shared types, chunk identifiers, status codes and the result record.
// ----------------------------------------------------------------------------
package rwp_pkg;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_CHDR,
    PH_BODY,
    PH_PAD,
    PH_DATA
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_NOTWAVE  = 4'd1,
    ST_TRUNC    = 4'd2,
    ST_FMTSHORT = 4'd3,
    ST_NOFMT    = 4'd4,
    ST_EMPTY    = 4'd5,
    ST_NOTPCM   = 4'd6,
    ST_CHANNELS = 4'd7,
    ST_BITS     = 4'd8,
    ST_RATE     = 4'd9,
    ST_NODATA   = 4'd10
  } status_e;

  localparam logic [31:0] RIFF_ID      = 32'h5249_4646;
  localparam logic [31:0] WAVE_ID      = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [3:0]  HDR_LAST_POS = 4'd11;
  localparam logic [2:0]  CHDR_LAST    = 3'd7;
  localparam logic [15:0] FMT_PCM      = 16'h0001;
  localparam logic [15:0] FMT_EXT      = 16'hFFFE;

  typedef struct packed {
    logic          byte_valid;
    logic [7:0]    sample_byte;
    logic          done;
    status_e       status;
    logic [1:0]    channels;
    logic [31:0]   rate;
    logic [4:0]    bits;
    logic [2:0]    align;
    logic [31:0]   byte_rate;
    logic [31:0]   data_len;
  } res_t;

  // Returns byte idx of a four-character code, first character at index 0.
  function automatic logic [7:0] id_byte(logic [31:0] id, logic [1:0] idx);
    logic [31:0] sh;
    sh = id >> {~idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage

[src/rwp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE PCM parser step logic
// Holds the parse state and computes the result of the registered byte.
// ----------------------------------------------------------------------------
module rwp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_vld_i,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          res_vld_o,
  output rwp_pkg::res_t res_o
);
  import rwp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [15:0] fmt_tag_q, fmt_tag_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        fin_q, fin_d;

  logic        emit, e_byte, e_done, clear, next_chunk;
  status_e     e_stat;
  logic [31:0] pos_inc, len_nx;
  logic        hdr_bad, is_pcm;
  logic [2:0]  align;
  logic [1:0]  rate_sh;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    len_d      = len_q;
    fmt_seen_d = fmt_seen_q;
    fmt_tag_d  = fmt_tag_q;
    chans_d    = chans_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    fin_d      = fin_q;
    emit       = 1'b0;
    e_byte     = 1'b0;
    e_done     = 1'b0;
    e_stat     = ST_OK;
    clear      = 1'b0;
    next_chunk = 1'b0;
    pos_inc    = pos_q + 32'd1;
    len_nx     = len_q | ({24'd0, byte_i} << {pos_q[1:0], 3'b000});
    hdr_bad    = ((pos_q[3:2] == 2'b00) && (byte_i != id_byte(RIFF_ID, pos_q[1:0]))) ||
                 ((pos_q[3:2] == 2'b10) && (byte_i != id_byte(WAVE_ID, pos_q[1:0])));
    is_pcm     = (fmt_tag_q == FMT_PCM) || (fmt_tag_q == FMT_EXT);

    if (fin_q) begin
      clear = last_i;
    end else begin
      case (phase_q)
        PH_HDR: begin
          if (hdr_bad) begin
            e_done = 1'b1;
            e_stat = ST_NOTWAVE;
          end else if (pos_q[3:0] == HDR_LAST_POS) begin
            if (last_i) begin
              e_done = 1'b1;
              e_stat = ST_NODATA;
            end else begin
              next_chunk = 1'b1;
            end
          end else if (last_i) begin
            e_done = 1'b1;
            e_stat = ST_NOTWAVE;
          end else begin
            pos_d = pos_inc;
          end
        end
        PH_CHDR: begin
          if (!pos_q[2]) begin
            tag_d = {tag_q[23:0], byte_i};
          end else begin
            len_d = len_nx;
          end
          if (pos_q[2:0] == CHDR_LAST) begin
            if (last_i && (len_nx != 32'd0)) begin
              e_done = 1'b1;
              e_stat = ST_TRUNC;
            end else if (tag_q == TAG_FMT) begin
              if (len_nx < FMT_MIN_LEN) begin
                e_done = 1'b1;
                e_stat = ST_FMTSHORT;
              end else begin
                fmt_seen_d = 1'b1;
                phase_d    = PH_BODY;
                pos_d      = 32'd0;
              end
            end else if (tag_q == TAG_DATA) begin
              e_done = 1'b1;
              if (!fmt_seen_q) begin
                e_stat = ST_NOFMT;
              end else if (len_nx == 32'd0) begin
                e_stat = ST_EMPTY;
              end else if (!is_pcm) begin
                e_stat = ST_NOTPCM;
              end else if ((chans_q != 16'd1) && (chans_q != 16'd2)) begin
                e_stat = ST_CHANNELS;
              end else if ((bits_q != 16'd8) && (bits_q != 16'd16)) begin
                e_stat = ST_BITS;
              end else if (rate_q == 32'd0) begin
                e_stat = ST_RATE;
              end else begin
                e_done  = 1'b0;
                phase_d = PH_DATA;
                pos_d   = 32'd0;
              end
            end else if (len_nx == 32'd0) begin
              if (last_i) begin
                e_done = 1'b1;
                e_stat = ST_NODATA;
              end else begin
                next_chunk = 1'b1;
              end
            end else begin
              phase_d = PH_BODY;
              pos_d   = 32'd0;
            end
          end else if (last_i) begin
            e_done = 1'b1;
            e_stat = ST_NODATA;
          end else begin
            pos_d = pos_inc;
          end
        end
        PH_BODY: begin
          if ((tag_q == TAG_FMT) && (pos_q[31:4] == 28'd0)) begin
            case (pos_q[3:0])
              4'd0:    fmt_tag_d[7:0]  = byte_i;
              4'd1:    fmt_tag_d[15:8] = byte_i;
              4'd2:    chans_d[7:0]    = byte_i;
              4'd3:    chans_d[15:8]   = byte_i;
              4'd4:    rate_d[7:0]     = byte_i;
              4'd5:    rate_d[15:8]    = byte_i;
              4'd6:    rate_d[23:16]   = byte_i;
              4'd7:    rate_d[31:24]   = byte_i;
              4'd14:   bits_d[7:0]     = byte_i;
              4'd15:   bits_d[15:8]    = byte_i;
              default: ;
            endcase
          end
          if (pos_inc >= len_q) begin
            if (last_i) begin
              e_done = 1'b1;
              e_stat = ST_NODATA;
            end else if (len_q[0]) begin
              phase_d = PH_PAD;
              pos_d   = 32'd0;
            end else begin
              next_chunk = 1'b1;
            end
          end else begin
            pos_d = pos_inc;
            if (last_i) begin
              e_done = 1'b1;
              e_stat = ST_TRUNC;
            end
          end
        end
        PH_PAD: begin
          if (last_i) begin
            e_done = 1'b1;
            e_stat = ST_NODATA;
          end else begin
            next_chunk = 1'b1;
          end
        end
        PH_DATA: begin
          pos_d  = pos_inc;
          e_byte = 1'b1;
          if (pos_inc >= len_q) begin
            e_done = 1'b1;
            e_stat = ST_OK;
          end else if (last_i) begin
            e_done = 1'b1;
            e_stat = ST_TRUNC;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end

    emit = e_byte | e_done;

    if (next_chunk) begin
      phase_d = PH_CHDR;
      pos_d   = 32'd0;
      tag_d   = 32'd0;
      len_d   = 32'd0;
    end

    if (e_done) begin
      if (last_i) begin
        clear = 1'b1;
      end else begin
        fin_d = 1'b1;
      end
    end

    if (clear) begin
      phase_d    = PH_HDR;
      pos_d      = 32'd0;
      tag_d      = 32'd0;
      len_d      = 32'd0;
      fmt_seen_d = 1'b0;
      fmt_tag_d  = 16'd0;
      chans_d    = 16'd0;
      rate_d     = 32'd0;
      bits_d     = 16'd0;
      fin_d      = 1'b0;
    end
  end

  assign align   = bits_q[4] ? {chans_q[1:0], 1'b0} : {1'b0, chans_q[1:0]};
  assign rate_sh = {1'b0, bits_q[4]} + {1'b0, chans_q[1]};

  always_comb begin
    res_o             = '0;
    res_o.byte_valid  = e_byte;
    res_o.sample_byte = e_byte ? byte_i : 8'd0;
    res_o.done        = e_done;
    res_o.status      = e_done ? e_stat : ST_OK;
    if (e_done && (e_stat == ST_OK)) begin
      res_o.channels  = chans_q[1:0];
      res_o.rate      = rate_q;
      res_o.bits      = bits_q[4:0];
      res_o.align     = align;
      res_o.byte_rate = rate_q << rate_sh;
      res_o.data_len  = len_q;
    end
  end

  assign res_vld_o = item_vld_i & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      pos_q      <= 32'd0;
      tag_q      <= 32'd0;
      len_q      <= 32'd0;
      fmt_seen_q <= 1'b0;
      fmt_tag_q  <= 16'd0;
      chans_q    <= 16'd0;
      rate_q     <= 32'd0;
      bits_q     <= 16'd0;
      fin_q      <= 1'b0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      fmt_seen_q <= fmt_seen_d;
      fmt_tag_q  <= fmt_tag_d;
      chans_q    <= chans_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      fin_q      <= fin_d;
    end
  end

endmodule

[src/rwp_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE PCM parser result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module rwp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  rwp_pkg::res_t res_i,
  input  logic          stall_i,
  output logic          ready_o,
  output logic          vld_o,
  output rwp_pkg::res_t res_o
);
  import rwp_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign ready_o = !vld_q || !stall_i;
  assign vld_d   = ready_o ? load_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

[src/riff_wave_pcm_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE PCM parser
// Parses a WAV byte stream, checks the PCM format and passes data bytes on.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle and sustains that rate without
// gaps while the output is not stalled. A byte is captured in an input
// register and stepped through the chunk parser when it is consumed. Its
// result, if any, is loaded into the result register on the same edge that
// consumes the byte. A stalled output holds back the input only when the
// waiting byte has a result to write. Header and non-data chunk bytes give
// no result unless they end the file with done; each data byte gives one,
// and exactly one result per file carries done with a status. When the
// status is truncated, data bytes already delivered belong to an incomplete
// file and should be dropped. After done, bytes are ignored up to and
// including the one marked last, after which the next file starts.
module riff_wave_pcm_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_valid_o,
  output logic [7:0]  sample_byte_o,
  output logic        done_res_o,
  output logic [3:0]  status_o,
  output logic [1:0]  channel_count_o,
  output logic [31:0] rate_hz_o,
  output logic [4:0]  bits_per_sample_o,
  output logic [2:0]  block_align_o,
  output logic [31:0] byte_rate_o,
  output logic [31:0] data_length_o
);
  import rwp_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       accept, consume, res_vld, out_ready;
  res_t       res, res_q;

  assign consume    = in_vld_q && (!res_vld || out_ready);
  assign in_stall_o = in_vld_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (consume ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= file_byte_i;
      in_last_q <= is_last_i;
    end
  end

  rwp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (in_vld_q),
    .take_i     (consume),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  rwp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (consume && res_vld),
    .res_i   (res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .vld_o   (out_valid_o),
    .res_o   (res_q)
  );

  assign byte_valid_o      = res_q.byte_valid;
  assign sample_byte_o     = res_q.sample_byte;
  assign done_res_o        = res_q.done;
  assign status_o          = res_q.status;
  assign channel_count_o   = res_q.channels;
  assign rate_hz_o         = res_q.rate;
  assign bits_per_sample_o = res_q.bits;
  assign block_align_o     = res_q.align;
  assign byte_rate_o       = res_q.byte_rate;
  assign data_length_o     = res_q.data_len;

  // The input side only backs up while a result waits on a stalled output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A result without done always carries a data byte.
  a_res_content : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> byte_valid_o)
    else $error("empty result presented");

  // Format fields are zero unless the file parsed successfully.
  a_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      ((rate_hz_o == 32'd0) && (data_length_o == 32'd0) && (block_align_o == 3'd0)))
    else $error("format fields set on failed parse");

  // A successful done reports a legal block alignment.
  a_align_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o && (status_o == ST_OK)) |->
      ((block_align_o == 3'd1) || (block_align_o == 3'd2) || (block_align_o == 3'd4)))
    else $error("illegal block alignment on successful parse");

endmodule
